>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication property holds at every rising clock edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition never becomes true
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/trht_pkg.sv
// ----------------------------------------------------------------------------
// Touch region hit test package
// Field widths, command and status codes, sequencer states and region layout.
// ----------------------------------------------------------------------------
package trht_pkg;

    localparam int REGION_SLOTS_DEF = 16;
    localparam int COORD_W          = 10;
    localparam int TAG_W            = 8;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int HIT_INDEX_W      = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_BIND  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TOUCH = 2'd2
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_HIT  = 2'd2,
        STATUS_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] bottom;
        logic [TAG_W-1:0]   tag;
    } t_region;

    localparam int REGION_W = $bits(t_region);

endpackage

>>> rtl/trht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, register the read word every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/trht_cmp.sv
// ----------------------------------------------------------------------------
// Region compare unit
// Tests one region against the touch point; shared by every step of a scan.
// ----------------------------------------------------------------------------
module trht_cmp (
    input  trht_pkg::t_region              i_region,
    input  logic [trht_pkg::COORD_W-1:0]   i_point_x,
    input  logic [trht_pkg::COORD_W-1:0]   i_point_y,
    output logic                           o_hit
);

    import trht_pkg::*;

    logic in_x;
    logic in_y;
    logic has_tag;

    // Inclusive bounds; inverted bounds never match
    assign in_x    = (i_point_x >= i_region.left) && (i_point_x <= i_region.right);
    assign in_y    = (i_point_y >= i_region.top)  && (i_point_y <= i_region.bottom);
    assign has_tag = (i_region.tag != '0);

    assign o_hit = in_x && in_y && has_tag;

endmodule

>>> rtl/touch_region_hit_test_core.sv
// ----------------------------------------------------------------------------
// Touch region hit test core
// Table of rectangular touch regions with bind, clear and touch lookup.
// ----------------------------------------------------------------------------
// Bind and clear each pass from the idle state through the emit state back to
// idle. A touch scans the table from entry 0 up to and including the first hit
// (all bound regions on a miss): the region table has one read port and the scan
// tests one entry per cycle in a single compare unit. An empty table answers a
// touch with a miss without a scan. The input stalls while a command is in
// progress; a finished result waits in the output register while the next
// command is taken.
// ----------------------------------------------------------------------------
module touch_region_hit_test_core #(
    parameter int REGION_SLOTS = trht_pkg::REGION_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [trht_pkg::CMD_W-1:0]        i_command,
    input  logic [trht_pkg::COORD_W-1:0]      i_left_edge,
    input  logic [trht_pkg::COORD_W-1:0]      i_right_edge,
    input  logic [trht_pkg::COORD_W-1:0]      i_top_edge,
    input  logic [trht_pkg::COORD_W-1:0]      i_bottom_edge,
    input  logic [trht_pkg::TAG_W-1:0]        i_handler_tag,
    input  logic [trht_pkg::COORD_W-1:0]      i_point_x,
    input  logic [trht_pkg::COORD_W-1:0]      i_point_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [trht_pkg::STATUS_W-1:0]     o_status,
    output logic [trht_pkg::HIT_INDEX_W-1:0]  o_hit_index,
    output logic [trht_pkg::TAG_W-1:0]        o_hit_tag
);

    import trht_pkg::*;

    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic [COORD_W-1:0]   r_px;
    logic [COORD_W-1:0]   r_py;
    t_status              r_res_status;
    t_status              n_res_status;
    logic [IDX_W-1:0]     r_res_index;
    logic [IDX_W-1:0]     n_res_index;
    logic [TAG_W-1:0]     r_res_tag;
    logic [TAG_W-1:0]     n_res_tag;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [HIT_INDEX_W-1:0] r_out_index;
    logic [TAG_W-1:0]     r_out_tag;

    logic                 in_accept;
    logic                 table_full;
    logic                 scan_last;
    logic                 out_free;
    logic                 out_load;
    logic                 entry_hit;
    logic                 ram_we;
    t_region              wr_region;
    t_region              rd_region;
    logic [REGION_W-1:0]  rd_data;
    logic [IDX_W+HIT_INDEX_W-1:0] idx_ext;

    // Handshake and scan status
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign table_full = (r_count == CNT_W'(REGION_SLOTS));
    assign scan_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_EMIT) && out_free;

    // Region table, written on bind, read one entry ahead of the scan
    assign wr_region = '{left:   i_left_edge,
                         right:  i_right_edge,
                         top:    i_top_edge,
                         bottom: i_bottom_edge,
                         tag:    i_handler_tag};

    trht_ram #(
        .WIDTH (REGION_W),
        .DEPTH (REGION_SLOTS),
        .ADDR_W(IDX_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(wr_region),
        .i_raddr(n_idx),
        .o_rdata(rd_data)
    );

    assign rd_region = rd_data;

    // Shared compare unit
    trht_cmp u_cmp (
        .i_region (rd_region),
        .i_point_x(r_px),
        .i_point_y(r_py),
        .o_hit    (entry_hit)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if ((i_command == CMD_TOUCH) && (r_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (entry_hit || scan_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: table write, count, scan index and result
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_tag    = r_res_tag;
        ram_we       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_res_status = STATUS_DONE;
                    n_res_index  = '0;
                    n_res_tag    = '0;
                    unique case (i_command)
                        CMD_BIND: begin
                            if (table_full) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_TOUCH: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_res_status = STATUS_MISS;
                            end
                        end
                        default: begin
                            n_res_status = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (entry_hit) begin
                    n_res_status = STATUS_HIT;
                    n_res_index  = r_idx;
                    n_res_tag    = rd_region.tag;
                end else if (scan_last) begin
                    n_res_status = STATUS_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                n_idx = r_idx;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Widen the scan index, then keep the reported bits
    assign idx_ext = {{HIT_INDEX_W{1'b0}}, r_res_index};

    // Payload registers: hold the touch point, result and output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_tag    <= n_res_tag;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= idx_ext[HIT_INDEX_W-1:0];
            r_out_tag    <= r_res_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_hit_index = r_out_index;
    assign o_hit_tag   = r_out_tag;

    // Checks
    `include "assert_macros.svh"

    `ASSERT_NEVER(a_count_in_range, r_count > CNT_W'(REGION_SLOTS), "region count overflow")
    `ASSERT_CLK(a_accept_leaves_idle, in_accept |=> (r_state != ST_IDLE), "idle after transfer")
    `ASSERT_CLK(a_scan_in_table, (r_state == ST_SCAN) |-> (CNT_W'(r_idx) < r_count), "scan past table")
    `ASSERT_CLK(a_hit_has_tag, (r_out_valid && (r_out_status == STATUS_HIT)) |-> (r_out_tag != '0), "hit without tag")

endmodule
